/* rtl/core/uartrx_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the UART receive engine with timeouts.
// Used by every module of the block; depends on nothing.
package uartrx_pkg;

	localparam int unsigned CFG_INDEX_WIDTH = 2;
	localparam int unsigned CFG_DATA_WIDTH  = 32;
	localparam int unsigned BYTE_CNT_WIDTH  = 16;
	localparam int unsigned TIMEOUT_WIDTH   = 32;
	localparam int unsigned RX_COUNT_WIDTH  = 16;

	localparam logic [CFG_INDEX_WIDTH-1:0] REG_BYTE_COUNT       = 2'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_INTERVAL_TIMEOUT = 2'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_TOTAL_TIMEOUT    = 2'd2;

	localparam logic [BYTE_CNT_WIDTH-1:0] BYTE_COUNT_RESET = 16'd0;
	localparam logic [TIMEOUT_WIDTH-1:0]  INTERVAL_RESET   = 32'd1000;
	localparam logic [TIMEOUT_WIDTH-1:0]  TOTAL_RESET      = 32'd1000;

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_POLL  = 1'b1;

	localparam logic [7:0] DATA_READY_MASK = 8'h01;
	localparam logic [7:0] LINE_ERROR_MASK = 8'h1E;

	localparam logic [1:0] ST_COMPLETE   = 2'd0;
	localparam logic [1:0] ST_LINE_ERROR = 2'd1;
	localparam logic [1:0] ST_INTERVAL   = 2'd2;
	localparam logic [1:0] ST_TOTAL      = 2'd3;

	typedef struct packed {
		logic                      byte_valid;
		logic [7:0]                rx_data;
		logic                      done_res;
		logic [1:0]                end_status;
		logic [RX_COUNT_WIDTH-1:0] received_count;
	} result_t;

	typedef struct packed {
		logic [BYTE_CNT_WIDTH-1:0] byte_count;
		logic [TIMEOUT_WIDTH-1:0]  interval_timeout;
		logic [TIMEOUT_WIDTH-1:0]  total_timeout;
	} cfg_t;

endpackage

/* rtl/core/uartrx_cfg.sv */
`timescale 1ns / 1ps
// Configuration registers of the UART receive engine.
// Depends on uartrx_pkg for register indexes and reset values.
module uartrx_cfg
	import uartrx_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [CFG_INDEX_WIDTH-1:0] wr_index,
	input  logic [CFG_DATA_WIDTH-1:0]  wr_data,
	output cfg_t                       cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.byte_count       <= BYTE_COUNT_RESET;
			cfg_q.interval_timeout <= INTERVAL_RESET;
			cfg_q.total_timeout    <= TOTAL_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_BYTE_COUNT:       cfg_q.byte_count       <= wr_data[BYTE_CNT_WIDTH-1:0];
				REG_INTERVAL_TIMEOUT: cfg_q.interval_timeout <= wr_data[TIMEOUT_WIDTH-1:0];
				REG_TOTAL_TIMEOUT:    cfg_q.total_timeout    <= wr_data[TIMEOUT_WIDTH-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* rtl/core/uartrx_engine.sv */
`timescale 1ns / 1ps
// Transfer state and the per-request check sequence of the receive engine.
// Depends on uartrx_pkg; the state advances on every accepted request.
module uartrx_engine
	import uartrx_pkg::*;
#(
	parameter int unsigned COUNT_WIDTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic       command,
	input  logic [7:0] line_status,
	input  logic [7:0] rx_byte,
	input  cfg_t       cfg,
	output result_t    res
);

	logic                     active_q;
	logic [COUNT_WIDTH-1:0]   bytes_left_q;
	logic [TIMEOUT_WIDTH-1:0] interval_left_q;
	logic [TIMEOUT_WIDTH-1:0] total_left_q;
	logic [COUNT_WIDTH-1:0]   bytes_received_q;

	logic                     active_n;
	logic [COUNT_WIDTH-1:0]   bytes_left_n;
	logic [TIMEOUT_WIDTH-1:0] interval_left_n;
	logic [TIMEOUT_WIDTH-1:0] total_left_n;
	logic [COUNT_WIDTH-1:0]   bytes_received_n;

	logic [COUNT_WIDTH+BYTE_CNT_WIDTH-1:0] load_ext;
	logic [COUNT_WIDTH+RX_COUNT_WIDTH-1:0] recv_ext;
	logic                                  data_ready;
	logic                                  line_error;

	assign load_ext   = {{COUNT_WIDTH{1'b0}}, cfg.byte_count};
	assign recv_ext   = {{RX_COUNT_WIDTH{1'b0}}, bytes_received_n};
	assign data_ready = (line_status & DATA_READY_MASK) != 8'h00;
	assign line_error = (line_status & LINE_ERROR_MASK) != 8'h00;

	always_comb begin
		active_n         = active_q;
		bytes_left_n     = bytes_left_q;
		interval_left_n  = interval_left_q;
		total_left_n     = total_left_q;
		bytes_received_n = bytes_received_q;
		res              = '0;
		if (command == CMD_START) begin
			active_n         = 1'b1;
			bytes_left_n     = load_ext[COUNT_WIDTH-1:0];
			interval_left_n  = cfg.interval_timeout;
			total_left_n     = cfg.total_timeout;
			bytes_received_n = '0;
		end else if (active_q) begin
			if (bytes_left_q == '0) begin
				res.done_res   = 1'b1;
				res.end_status = ST_COMPLETE;
			end else begin
				if (data_ready) begin
					res.byte_valid   = 1'b1;
					res.rx_data      = rx_byte;
					interval_left_n  = cfg.interval_timeout;
					bytes_received_n = bytes_received_q + 1'b1;
					bytes_left_n     = bytes_left_q - 1'b1;
				end
				// The interval check sees the reloaded value when a byte arrived.
				priority if (line_error) begin
					res.done_res   = 1'b1;
					res.end_status = ST_LINE_ERROR;
				end else if (interval_left_n == '0) begin
					res.done_res   = 1'b1;
					res.end_status = ST_INTERVAL;
				end else if (total_left_q == '0) begin
					res.done_res   = 1'b1;
					res.end_status = ST_TOTAL;
				end else begin
					total_left_n    = total_left_q - 1'b1;
					interval_left_n = interval_left_n - 1'b1;
				end
			end
			if (res.done_res) begin
				active_n = 1'b0;
			end
		end
		res.received_count = recv_ext[RX_COUNT_WIDTH-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q         <= 1'b0;
			bytes_left_q     <= '0;
			interval_left_q  <= '0;
			total_left_q     <= '0;
			bytes_received_q <= '0;
		end else if (step) begin
			active_q         <= active_n;
			bytes_left_q     <= bytes_left_n;
			interval_left_q  <= interval_left_n;
			total_left_q     <= total_left_n;
			bytes_received_q <= bytes_received_n;
		end
	end

endmodule

/* rtl/core/uartrx_outreg.sv */
`timescale 1ns / 1ps
// Result register of the receive engine with its valid/ready handshake.
// Depends on uartrx_pkg for the result type.
module uartrx_outreg
	import uartrx_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t res_in,
	output logic    can_load,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t res_out
);

	logic    valid_q;
	result_t res_q;

	assign can_load = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

	assign out_valid = valid_q;
	assign res_out   = res_q;

endmodule

/* rtl/core/uart_receive_with_timeouts.sv */
`timescale 1ns / 1ps
// UART receive engine with inter-byte and whole-transfer timeouts, top level.
// Instantiates uartrx_cfg, uartrx_engine and uartrx_outreg; uses uartrx_pkg.
//
// The block takes one request per clock cycle while it can load its result
// register, and returns exactly one result per request from that register in
// the cycle after acceptance. A request is taken whenever that register is
// empty or being emptied in the same cycle, so a stalled output holds at most
// one finished result. All counter checks and updates for a request are made
// at acceptance against the transfer state registers. Config writes never stall.
module uart_receive_with_timeouts
	import uartrx_pkg::*;
#(
	parameter int unsigned COUNT_WIDTH = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       command,
	input  logic [7:0]                 line_status,
	input  logic [7:0]                 rx_byte,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       byte_valid,
	output logic [7:0]                 rx_data,
	output logic                       done_res,
	output logic [1:0]                 end_status,
	output logic [RX_COUNT_WIDTH-1:0]  received_count
);

	cfg_t    cfg;
	result_t res_next;
	result_t res_reg;
	logic    accept;

	assign cfg_ready = 1'b1;
	assign accept    = in_valid && in_ready;

	uartrx_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	uartrx_engine #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (accept),
		.command     (command),
		.line_status (line_status),
		.rx_byte     (rx_byte),
		.cfg         (cfg),
		.res         (res_next)
	);

	uartrx_outreg u_outreg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept),
		.res_in    (res_next),
		.can_load  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res_out   (res_reg)
	);

	assign byte_valid     = res_reg.byte_valid;
	assign rx_data        = res_reg.rx_data;
	assign done_res       = res_reg.done_res;
	assign end_status     = res_reg.end_status;
	assign received_count = res_reg.received_count;

endmodule

/* rtl/core/uartrx_checker.sv */
`timescale 1ns / 1ps
// Port-level checks of the UART receive engine, bound to the top level.
// Depends on uartrx_pkg and uart_receive_with_timeouts.
module uartrx_checker
	import uartrx_pkg::*;
(
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      command,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic                      byte_valid,
	input logic [7:0]                rx_data,
	input logic                      done_res,
	input logic [1:0]                end_status,
	input logic [RX_COUNT_WIDTH-1:0] received_count
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(byte_valid) && $stable(rx_data)
			&& $stable(done_res) && $stable(end_status) && $stable(received_count))
		else $error("Stalled result changed or was dropped.");

	a_status_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !done_res |-> end_status == ST_COMPLETE)
		else $error("End status set on a result that did not end the transfer.");

	a_data_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !byte_valid |-> rx_data == 8'h00)
		else $error("Receive data nonzero without a delivered byte.");

	a_start_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && command == CMD_START |=>
			out_valid && !byte_valid && !done_res && received_count == '0)
		else $error("Start request did not give a cleared result.");

endmodule

bind uart_receive_with_timeouts uartrx_checker u_checker (.*);

/* tb/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for uart_receive_with_timeouts: directed and random requests
// checked field by field against a cycle-free predictor. Depends on uartrx_pkg and the RTL.
module testbench;
	import uartrx_pkg::*;

	localparam int unsigned COUNT_W     = 16;
	localparam int unsigned CYCLE_LIMIT = 300000;

	// Index 3 decodes to no register, so writes to it must be ignored.
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNUSED = 2'd3;

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [CFG_INDEX_WIDTH-1:0] cfg_index;
	logic [CFG_DATA_WIDTH-1:0]  cfg_data;
	logic                       in_valid;
	logic                       in_ready;
	logic                       command;
	logic [7:0]                 line_status;
	logic [7:0]                 rx_byte;
	logic                       out_valid;
	logic                       out_ready;
	logic                       byte_valid;
	logic [7:0]                 rx_data;
	logic                       done_res;
	logic [1:0]                 end_status;
	logic [RX_COUNT_WIDTH-1:0]  received_count;

	logic [BYTE_CNT_WIDTH-1:0] reg_byte_count = BYTE_COUNT_RESET;
	logic [TIMEOUT_WIDTH-1:0]  reg_interval   = INTERVAL_RESET;
	logic [TIMEOUT_WIDTH-1:0]  reg_total      = TOTAL_RESET;

	logic                      xfer_active   = 1'b0;
	logic [COUNT_W-1:0]        bytes_left    = '0;
	logic [TIMEOUT_WIDTH-1:0]  interval_left = '0;
	logic [TIMEOUT_WIDTH-1:0]  total_left    = '0;
	logic [RX_COUNT_WIDTH-1:0] bytes_seen    = '0;

	result_t pending_results[$];
	int      mismatch_count = 0;
	int      cycle_count    = 0;
	int      hold_request   = 0;
	bit      idling         = 1'b1;

	uart_receive_with_timeouts #(
		.COUNT_WIDTH(COUNT_W)
	) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.command       (command),
		.line_status   (line_status),
		.rx_byte       (rx_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.byte_valid    (byte_valid),
		.rx_data       (rx_data),
		.done_res      (done_res),
		.end_status    (end_status),
		.received_count(received_count)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count = cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic result_t predict_rx_result(input logic cmd, input logic [7:0] status,
			input logic [7:0] data);
		result_t res;
		res = '0;
		if (cmd == CMD_START) begin
			xfer_active   = 1'b1;
			bytes_left    = COUNT_W'(reg_byte_count);
			interval_left = reg_interval;
			total_left    = reg_total;
			bytes_seen    = '0;
		end else if (xfer_active) begin
			if (bytes_left == '0) begin
				res.done_res   = 1'b1;
				res.end_status = ST_COMPLETE;
			end else begin
				if ((status & DATA_READY_MASK) != '0) begin
					res.byte_valid = 1'b1;
					res.rx_data    = data;
					interval_left  = reg_interval;
					bytes_seen     = bytes_seen + 1'b1;
					bytes_left     = bytes_left - 1'b1;
				end
				if ((status & LINE_ERROR_MASK) != '0) begin
					res.done_res   = 1'b1;
					res.end_status = ST_LINE_ERROR;
				end else if (interval_left == '0) begin
					res.done_res   = 1'b1;
					res.end_status = ST_INTERVAL;
				end else if (total_left == '0) begin
					res.done_res   = 1'b1;
					res.end_status = ST_TOTAL;
				end else begin
					total_left    = total_left - 1'b1;
					interval_left = interval_left - 1'b1;
				end
			end
			if (res.done_res)
				xfer_active = 1'b0;
		end
		res.received_count = bytes_seen;
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $realtime);
		mismatch_count++;
	endtask

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with no request outstanding", 32'(received_count), '0);
			end else begin
				want = pending_results.pop_front();
				if (byte_valid !== want.byte_valid)
					report_mismatch("byte_valid", 32'(byte_valid), 32'(want.byte_valid));
				if (rx_data !== want.rx_data)
					report_mismatch("rx_data", 32'(rx_data), 32'(want.rx_data));
				if (done_res !== want.done_res)
					report_mismatch("done_res", 32'(done_res), 32'(want.done_res));
				if (end_status !== want.end_status)
					report_mismatch("end_status", 32'(end_status), 32'(want.end_status));
				if (received_count !== want.received_count)
					report_mismatch("received_count", 32'(received_count),
						32'(want.received_count));
			end
		end
	end

	// Result side: random stall bursts while idling is set, plus one long hold when a test asks for it.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				out_ready <= 1'b0;
				repeat (hold_request - 1) @(negedge clk);
				hold_request = 0;
			end else if (idling && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(0, 11)) @(negedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic send_request(input logic cmd, input logic [7:0] status, input logic [7:0] data);
		int gap;
		gap = (idling && $urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid    <= 1'b1;
		command     <= cmd;
		line_status <= status;
		rx_byte     <= data;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pending_results.push_back(predict_rx_result(cmd, status, data));
	endtask

	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_INDEX_WIDTH-1:0] idx,
			input logic [CFG_DATA_WIDTH-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_BYTE_COUNT:       reg_byte_count = value[BYTE_CNT_WIDTH-1:0];
			REG_INTERVAL_TIMEOUT: reg_interval   = value[TIMEOUT_WIDTH-1:0];
			REG_TOTAL_TIMEOUT:    reg_total      = value[TIMEOUT_WIDTH-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_traffic(input int count);
		int         ready_pct;
		logic [3:0] errors;
		logic [7:0] status;
		ready_pct = $urandom_range(30, 95);
		for (int i = 0; i < count; i++) begin
			errors = ($urandom_range(0, 24) == 0) ? 4'($urandom_range(1, 15)) : 4'd0;
			status = {3'($urandom_range(0, 7)), errors, ($urandom_range(1, 100) <= ready_pct)};
			if (xfer_active ? ($urandom_range(0, 49) == 0) : ($urandom_range(0, 9) != 0))
				send_request(CMD_START, status, 8'($urandom()));
			else
				send_request(CMD_POLL, status, 8'($urandom()));
		end
	endtask

	task automatic test_idle_and_empty_transfer();
		send_request(CMD_POLL, 8'hFF, 8'hFF);
		send_request(CMD_START, 8'h00, 8'h00);
		send_request(CMD_POLL, 8'h01, 8'hA5);
		send_request(CMD_POLL, 8'h00, 8'h00);
		wait_idle();
	endtask

	task automatic test_byte_delivery();
		write_register(REG_BYTE_COUNT, 32'd3);
		write_register(REG_INTERVAL_TIMEOUT, 32'd5);
		write_register(REG_TOTAL_TIMEOUT, 32'd20);
		send_request(CMD_START, 8'h00, 8'h00);
		send_request(CMD_POLL, 8'h01, 8'h00);
		send_request(CMD_POLL, 8'h00, 8'h3C);
		send_request(CMD_POLL, 8'hE1, 8'hFF);
		send_request(CMD_POLL, 8'h01, 8'h5A);
		send_request(CMD_POLL, 8'h00, 8'h00);
		wait_idle();
	endtask

	task automatic test_line_errors();
		logic [7:0] error_status [4] = '{8'h03, 8'h04, 8'h08, 8'h10};
		write_register(REG_BYTE_COUNT, 32'd4);
		foreach (error_status[i]) begin
			send_request(CMD_START, 8'h00, 8'h00);
			send_request(CMD_POLL, error_status[i], 8'h70 + 8'(i));
		end
		wait_idle();
	endtask

	task automatic test_timeouts();
		write_register(REG_INTERVAL_TIMEOUT, 32'd0);
		send_request(CMD_START, 8'h00, 8'h00);
		send_request(CMD_POLL, 8'h00, 8'h00);
		send_request(CMD_START, 8'h00, 8'h00);
		send_request(CMD_POLL, 8'h01, 8'h81);
		wait_idle();
		write_register(REG_INTERVAL_TIMEOUT, 32'd5);
		write_register(REG_TOTAL_TIMEOUT, 32'd0);
		send_request(CMD_START, 8'h00, 8'h00);
		send_request(CMD_POLL, 8'h00, 8'h00);
		send_request(CMD_START, 8'h00, 8'h00);
		send_request(CMD_START, 8'hFF, 8'hFF);
		send_request(CMD_POLL, 8'h01, 8'h42);
		wait_idle();
	endtask

	task automatic test_register_extremes();
		write_register(REG_UNUSED, 32'hFFFF_FFFF);
		write_register(REG_BYTE_COUNT, 32'hFFFF_FFFF);
		write_register(REG_INTERVAL_TIMEOUT, 32'hFFFF_FFFF);
		write_register(REG_TOTAL_TIMEOUT, 32'hFFFF_FFFF);
		send_request(CMD_START, 8'h00, 8'h00);
		send_request(CMD_POLL, 8'h01, 8'hFF);
		send_request(CMD_POLL, 8'h00, 8'h00);
		send_request(CMD_POLL, 8'hFF, 8'h00);
		wait_idle();
	endtask

	task automatic test_output_backpressure();
		write_register(REG_BYTE_COUNT, 32'd40);
		write_register(REG_INTERVAL_TIMEOUT, 32'd100);
		write_register(REG_TOTAL_TIMEOUT, 32'd1000);
		hold_request = 150;
		send_request(CMD_START, 8'h00, 8'h00);
		repeat (30)
			send_request(CMD_POLL, 8'h01, 8'($urandom()));
		wait_idle();
	endtask

	task automatic test_random_transfers();
		for (int phase = 0; phase < 14; phase++) begin
			idling = ($urandom_range(0, 4) != 0);
			if ($urandom_range(0, 3) != 0)
				case ($urandom_range(0, 7))
					0:       write_register(REG_BYTE_COUNT, 32'hFFFF_FFFF);
					1:       write_register(REG_BYTE_COUNT, $urandom());
					default: write_register(REG_BYTE_COUNT, $urandom_range(0, 10));
				endcase
			if ($urandom_range(0, 3) != 0)
				case ($urandom_range(0, 7))
					0:       write_register(REG_INTERVAL_TIMEOUT, 32'hFFFF_FFFF);
					1:       write_register(REG_INTERVAL_TIMEOUT, $urandom());
					default: write_register(REG_INTERVAL_TIMEOUT, $urandom_range(0, 8));
				endcase
			if ($urandom_range(0, 3) != 0)
				case ($urandom_range(0, 7))
					0:       write_register(REG_TOTAL_TIMEOUT, 32'hFFFF_FFFF);
					1:       write_register(REG_TOTAL_TIMEOUT, $urandom());
					default: write_register(REG_TOTAL_TIMEOUT, $urandom_range(0, 40));
				endcase
			if ($urandom_range(0, 9) == 0)
				write_register(REG_UNUSED, $urandom());
			run_traffic(100);
			wait_idle();
		end
	endtask

	task automatic test_steady_stream();
		idling = 1'b0;
		write_register(REG_BYTE_COUNT, 32'd6);
		write_register(REG_INTERVAL_TIMEOUT, 32'd4);
		write_register(REG_TOTAL_TIMEOUT, 32'd30);
		run_traffic(150);
		wait_idle();
	endtask

	initial begin
		arst_n      = 1'b0;
		cfg_valid   = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		in_valid    = 1'b0;
		command     = CMD_START;
		line_status = '0;
		rx_byte     = '0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		test_idle_and_empty_transfer();
		test_byte_delivery();
		test_line_errors();
		test_timeouts();
		test_register_extremes();
		test_output_backpressure();
		test_random_transfers();
		test_steady_stream();

		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
